/* rtl/jsu_pkg.sv */
// Package for the JSON string unescaper: phase, result kind and error codes,
// and the per-byte result bundle passed from the decoder to the emitter.
// No dependencies.
package jsu_pkg;

	// Decoder phase, four bits wide
	typedef enum logic [3:0] {
		PH_IDLE    = 4'd0,
		PH_BODY    = 4'd1,
		PH_ESC     = 4'd2,
		PH_HEX1    = 4'd3,
		PH_BSL     = 4'd4,
		PH_U       = 4'd5,
		PH_HEX2    = 4'd6,
		PH_DISCARD = 4'd7
	} phase_t;

	// Result kind
	typedef enum logic [1:0] {
		KIND_DATA = 2'd0,
		KIND_END  = 2'd1,
		KIND_ERR  = 2'd2
	} kind_t;

	// Error codes
	typedef enum logic [3:0] {
		ERR_NO_OPEN    = 4'd0,
		ERR_CONTROL    = 4'd1,
		ERR_CUT_ESC    = 4'd2,
		ERR_BAD_ESC    = 4'd3,
		ERR_CUT_HEX    = 4'd4,
		ERR_BAD_HEX    = 4'd5,
		ERR_NO_LOW     = 4'd6,
		ERR_BAD_LOW    = 4'd7,
		ERR_STRAY_LOW  = 4'd8,
		ERR_UNTERM     = 4'd9
	} err_t;

	localparam int MAX_DATA = 4;

	// Everything one input byte produces: up to four data bytes, then at
	// most one closing item (end of string or error)
	typedef struct packed {
		logic [MAX_DATA-1:0][7:0] data;
		logic [2:0]               n_data;
		logic                     tail;
		kind_t                    tail_kind;
		err_t                     tail_code;
	} bundle_t;

endpackage

/* rtl/jsu_decode.sv */
// Byte decoder: holds the string-parsing state and combinationally turns one
// input byte into a result bundle.
// Depends on jsu_pkg.
module jsu_decode (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             acc,
	input  logic [7:0]       in_byte,
	input  logic             in_last,
	output jsu_pkg::bundle_t bundle
);
	import jsu_pkg::*;

	typedef struct packed {
		logic [MAX_DATA-1:0][7:0] b;
		logic [2:0]               n;
	} utf8_t;

	typedef struct packed {
		logic       ok;
		logic [3:0] val;
	} hexd_t;

	// Encode a code point as UTF-8, first byte in the lowest slot
	function automatic utf8_t utf8_encode(input logic [20:0] cp);
		utf8_t r;
		r = '0;
		if (cp[20:7] == '0) begin
			r.b[0] = cp[7:0];
			r.n    = 3'd1;
		end else if (cp[20:11] == '0) begin
			r.b[0] = {3'b110, cp[10:6]};
			r.b[1] = {2'b10, cp[5:0]};
			r.n    = 3'd2;
		end else if (cp[20:16] == '0) begin
			r.b[0] = {4'b1110, cp[15:12]};
			r.b[1] = {2'b10, cp[11:6]};
			r.b[2] = {2'b10, cp[5:0]};
			r.n    = 3'd3;
		end else begin
			r.b[0] = {5'b11110, cp[20:18]};
			r.b[1] = {2'b10, cp[17:12]};
			r.b[2] = {2'b10, cp[11:6]};
			r.b[3] = {2'b10, cp[5:0]};
			r.n    = 3'd4;
		end
		return r;
	endfunction

	// Map an ASCII hex digit to its value
	function automatic hexd_t hex_digit(input logic [7:0] c);
		hexd_t r;
		r = '0;
		if (c >= 8'h30 && c <= 8'h39) begin
			r.ok  = 1'b1;
			r.val = c[3:0];
		end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
			r.ok  = 1'b1;
			r.val = c[3:0] + 4'd9;
		end
		return r;
	endfunction

	phase_t      phase_q, phase_n;
	logic [1:0]  dcnt_q, dcnt_n;
	logic [15:0] hex_q, hex_n;
	logic [9:0]  high_q, high_n;

	hexd_t       hd;
	logic [15:0] quad;
	logic [20:0] cp;
	utf8_t       enc;
	logic        is_high, is_low;

	// Code point for the current quad, or for a surrogate pair
	assign hd      = hex_digit(in_byte);
	assign quad    = {hex_q[11:0], hd.val};
	assign is_high = (quad >= 16'hd800) && (quad <= 16'hdbff);
	assign is_low  = (quad >= 16'hdc00) && (quad <= 16'hdfff);
	assign cp      = (phase_q == PH_HEX2) ? 21'h10000 + {1'b0, high_q, quad[9:0]}
	                                       : {5'b0, quad};
	assign enc     = utf8_encode(cp);

	// Next state and result bundle
	always_comb begin
		phase_n = phase_q;
		dcnt_n  = dcnt_q;
		hex_n   = hex_q;
		high_n  = high_q;
		bundle  = '0;
		bundle.tail_kind = KIND_ERR;
		bundle.tail_code = ERR_NO_OPEN;

		unique case (phase_q)
			PH_BODY: begin
				if (in_byte == 8'h22) begin
					bundle.tail      = 1'b1;
					bundle.tail_kind = KIND_END;
					phase_n          = PH_IDLE;
				end else if (in_byte < 8'h20) begin
					bundle.tail      = 1'b1;
					bundle.tail_code = ERR_CONTROL;
				end else if (in_byte == 8'h5c) begin
					phase_n = PH_ESC;
					if (in_last) begin
						bundle.tail      = 1'b1;
						bundle.tail_code = ERR_CUT_ESC;
					end
				end else begin
					bundle.data[0] = in_byte;
					bundle.n_data  = 3'd1;
					if (in_last) begin
						bundle.tail      = 1'b1;
						bundle.tail_code = ERR_UNTERM;
					end
				end
			end
			PH_ESC: begin
				case (in_byte)
					8'h22, 8'h5c, 8'h2f: bundle.data[0] = in_byte;
					8'h62:               bundle.data[0] = 8'h08;
					8'h66:               bundle.data[0] = 8'h0c;
					8'h6e:               bundle.data[0] = 8'h0a;
					8'h72:               bundle.data[0] = 8'h0d;
					8'h74:               bundle.data[0] = 8'h09;
					default:             bundle.data[0] = 8'h00;
				endcase
				if (in_byte inside {8'h22, 8'h5c, 8'h2f, 8'h62, 8'h66, 8'h6e, 8'h72,
						8'h74}) begin
					bundle.n_data = 3'd1;
					phase_n       = PH_BODY;
					if (in_last) begin
						bundle.tail      = 1'b1;
						bundle.tail_code = ERR_UNTERM;
					end
				end else if (in_byte == 8'h75) begin
					dcnt_n  = 2'd0;
					hex_n   = 16'h0;
					phase_n = PH_HEX1;
					if (in_last) begin
						bundle.tail      = 1'b1;
						bundle.tail_code = ERR_CUT_HEX;
					end
				end else begin
					bundle.tail      = 1'b1;
					bundle.tail_code = ERR_BAD_ESC;
				end
			end
			PH_HEX1, PH_HEX2: begin
				if (!hd.ok) begin
					bundle.tail      = 1'b1;
					bundle.tail_code = ERR_BAD_HEX;
				end else begin
					hex_n = quad;
					if (dcnt_q == 2'd3) begin
						dcnt_n = 2'd0;
						if (phase_q == PH_HEX1 && is_high) begin
							high_n  = quad[9:0];
							phase_n = PH_BSL;
							if (in_last) begin
								bundle.tail      = 1'b1;
								bundle.tail_code = ERR_NO_LOW;
							end
						end else if (phase_q == PH_HEX1 && is_low) begin
							bundle.tail      = 1'b1;
							bundle.tail_code = ERR_STRAY_LOW;
						end else if (phase_q == PH_HEX2 && !is_low) begin
							bundle.tail      = 1'b1;
							bundle.tail_code = ERR_BAD_LOW;
						end else begin
							bundle.data   = enc.b;
							bundle.n_data = enc.n;
							phase_n       = PH_BODY;
							if (in_last) begin
								bundle.tail      = 1'b1;
								bundle.tail_code = ERR_UNTERM;
							end
						end
					end else begin
						dcnt_n = dcnt_q + 2'd1;
						if (in_last) begin
							bundle.tail      = 1'b1;
							bundle.tail_code = ERR_CUT_HEX;
						end
					end
				end
			end
			PH_BSL: begin
				if (in_byte == 8'h5c) begin
					phase_n = PH_U;
					if (in_last) begin
						bundle.tail      = 1'b1;
						bundle.tail_code = ERR_NO_LOW;
					end
				end else begin
					bundle.tail      = 1'b1;
					bundle.tail_code = ERR_NO_LOW;
				end
			end
			PH_U: begin
				if (in_byte == 8'h75) begin
					dcnt_n  = 2'd0;
					hex_n   = 16'h0;
					phase_n = PH_HEX2;
					if (in_last) begin
						bundle.tail      = 1'b1;
						bundle.tail_code = ERR_CUT_HEX;
					end
				end else begin
					bundle.tail      = 1'b1;
					bundle.tail_code = ERR_NO_LOW;
				end
			end
			PH_DISCARD: begin
				if (in_last) begin
					phase_n = PH_IDLE;
				end
			end
			default: begin
				if (in_byte == 8'h22) begin
					phase_n = PH_BODY;
					if (in_last) begin
						bundle.tail      = 1'b1;
						bundle.tail_code = ERR_UNTERM;
					end
				end else begin
					bundle.tail      = 1'b1;
					bundle.tail_code = ERR_NO_OPEN;
				end
			end
		endcase

		// Any error drops into discard, or straight back to idle on the last byte
		if (bundle.tail && bundle.tail_kind == KIND_ERR) begin
			phase_n = in_last ? PH_IDLE : PH_DISCARD;
		end
	end

	// Advance the parse state on each accepted transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			dcnt_q  <= 2'd0;
			hex_q   <= 16'h0;
			high_q  <= 10'h0;
		end else if (acc) begin
			phase_q <= phase_n;
			dcnt_q  <= dcnt_n;
			hex_q   <= hex_n;
			high_q  <= high_n;
		end
	end

endmodule

/* rtl/jsu_emit.sv */
// Result emitter: holds one result bundle and sends its items one per
// transaction on the output stream, flagging the last one.
// Depends on jsu_pkg.
module jsu_emit (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             load,
	input  jsu_pkg::bundle_t bundle,
	output logic             free,
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [15:0]      m_tdata,
	output logic             m_tlast,
	output logic [1:0]       m_tuser
);
	import jsu_pkg::*;

	bundle_t    bnd_s1;
	logic       busy_q;
	logic [2:0] idx_q;
	logic [2:0] total;
	logic       on_data;
	logic       is_last;
	kind_t      cur_kind;
	logic [7:0] cur_byte;
	err_t       cur_code;

	assign total   = bnd_s1.n_data + {2'b0, bnd_s1.tail};
	assign on_data = idx_q < bnd_s1.n_data;
	assign is_last = idx_q == total - 3'd1;

	// Select the current item: data bytes first, then the closing item
	always_comb begin
		if (on_data) begin
			cur_kind = KIND_DATA;
			cur_byte = bnd_s1.data[idx_q[1:0]];
			cur_code = ERR_NO_OPEN;
		end else begin
			cur_kind = bnd_s1.tail_kind;
			cur_byte = 8'h00;
			cur_code = (bnd_s1.tail_kind == KIND_ERR) ? bnd_s1.tail_code : ERR_NO_OPEN;
		end
	end

	assign m_tvalid = busy_q;
	assign m_tdata  = {4'b0, cur_code, cur_byte};
	assign m_tuser  = cur_kind;
	assign m_tlast  = is_last;
	assign free     = !busy_q || (m_tready && is_last);

	// Hold the bundle payload
	always_ff @(posedge clk) begin
		if (load) begin
			bnd_s1 <= bundle;
		end
	end

	// Step through the items, reload when a new bundle arrives
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= 3'd0;
		end else if (load) begin
			busy_q <= 1'b1;
			idx_q  <= 3'd0;
		end else if (busy_q && m_tready) begin
			if (is_last) begin
				busy_q <= 1'b0;
			end
			idx_q <= idx_q + 3'd1;
		end
	end

endmodule

/* rtl/json_string_unescape_utf8.sv */
// Channel  Dir  Signals                          Contents (low bit up)
// s        in   s_tvalid s_tready s_tdata s_tlast  tdata: in_byte[7:0]; tlast: in_last
// m        out  m_tvalid m_tready m_tdata m_tlast  tdata: out_byte[7:0], error_code[11:8],
//                 m_tuser                          zero[15:12]; tuser: kind; tlast: run_end
//
// Each input byte is decoded in the cycle it is accepted and its results
// (0 to 5) land in one result register; they leave one per cycle while m_tready
// is high. A byte with n results holds the output until all n are taken; a byte
// that yields no result leaves the output untouched. The next byte is
// accepted while the last result of the previous one is being taken. Reset
// returns to waiting for an opening quote with an empty output. Output stalls
// back up into s_tready.
// Top level of the JSON string unescaper; depends on jsu_pkg, jsu_decode, jsu_emit.
module json_string_unescape_utf8 (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // in_byte[7:0]
	input  logic        s_tlast,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // out_byte[7:0], error_code[11:8], zero[15:12]
	output logic        m_tlast,
	output logic [1:0]  m_tuser    // kind[1:0]
);
	import jsu_pkg::*;

	bundle_t bundle;
	logic    acc;
	logic    load;
	logic    free;

	assign s_tready = free;
	assign acc      = s_tvalid && s_tready;
	// Load the emitter only when the byte produced something
	assign load     = acc && (bundle.n_data != 3'd0 || bundle.tail);

	jsu_decode u_decode (
		.clk     (clk),
		.arst_n  (arst_n),
		.acc     (acc),
		.in_byte (s_tdata),
		.in_last (s_tlast),
		.bundle  (bundle)
	);

	jsu_emit u_emit (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (load),
		.bundle   (bundle),
		.free     (free),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser)
	);

endmodule
